[design/ddsim_pkg.sv]
// ----------------------------------------------------------------------------
// ddsim_pkg: shared types and constants of the degree-day snow and ice melt
// Field widths, register indexes, reset values, saturation limits, rounding offsets and state codes.
// ----------------------------------------------------------------------------
package ddsim_pkg;

  // Field widths
  localparam int unsigned TempW   = 14;
  localparam int unsigned PrecipW = 16;
  localparam int unsigned AreaW   = 17;
  localparam int unsigned CorrW   = 16;
  localparam int unsigned FactorW = 13;
  localparam int unsigned StoreW  = 24;
  localparam int unsigned SnowW   = 18;
  localparam int unsigned RunW    = 25;
  localparam int unsigned MulAW   = 25;
  localparam int unsigned MulBW   = 17;
  localparam int unsigned ProdW   = MulAW + MulBW;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 208;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SNOW_CORR  = 3'd0,
    REG_RAIN_THR   = 3'd1,
    REG_MELT_THR   = 3'd2,
    REG_SNOW_FACT  = 3'd3,
    REG_ICE_FACT   = 3'd4,
    REG_INIT_STORE = 3'd5
  } cfg_reg_e;

  // Register reset values
  localparam logic [CorrW-1:0]   SnowCorrRst  = 16'd16384;
  localparam logic [FactorW-1:0] SnowFactRst  = 13'd768;
  localparam logic [FactorW-1:0] IceFactRst   = 13'd1536;

  // Saturation limits
  localparam logic [StoreW-1:0] StoreMax = {StoreW{1'b1}};
  localparam logic [RunW-1:0]   RunMax   = {RunW{1'b1}};

  // Rounding offsets
  localparam logic [ProdW-1:0] SnowRnd = ProdW'(1) << 13;
  localparam logic [ProdW-1:0] MeltRnd = ProdW'(1) << 7;
  localparam logic [ProdW-1:0] RunRnd  = ProdW'(1) << 15;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SNOW = 6'b000010,
    ST_MELT = 6'b000100,
    ST_UPD  = 6'b001000,
    ST_RUN  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

endpackage

[design/degree_day_snow_ice_melt.sv]
// ----------------------------------------------------------------------------
// degree_day_snow_ice_melt: degree-day snow and glacier-ice melt, one step
// Splits precipitation into rain and corrected snow, keeps the snow store,
// melts snow or bare ice above the melt threshold and reports the runoff.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                        Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready    one time step
//  m_axis    out        m_axis_tvalid / m_axis_tready    one result per step
//  cfg       in         cfg_we_i (no back-pressure)      register index + data
//
//  An item holds the block for the accept cycle and five sequencer steps around
//  the single 25x17 multiplier; its result enters the output register as the
//  last step ends, once that register is free. The input is ready only when
//  idle; a stalled result waits in the output register while the next item
//  runs, and that item waits in its last step until the register frees up.
//  Reset empties the store and restores register defaults and handshake state.
// ----------------------------------------------------------------------------
module degree_day_snow_ice_melt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // first_step[0], air_temp[14:1], precipitation[30:15], area_scale[47:31]
  input  logic [ddsim_pkg::InDataW-1:0]     s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // rain_out[15:0], snow_out[33:16], snow_store_out[57:34],
  // snow_melt_out[81:58], ice_melt_out[105:82], total_melt_out[129:106],
  // accumulation_out[154:130], runoff_out[179:155],
  // scaled_runoff_out[204:180], zero fill above
  output logic [ddsim_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [ddsim_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ddsim_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned ProdW  = ddsim_pkg::ProdW;
  localparam int unsigned StoreW = ddsim_pkg::StoreW;
  localparam int unsigned RunW   = ddsim_pkg::RunW;
  localparam int unsigned SnowW  = ddsim_pkg::SnowW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ddsim_pkg::CorrW-1:0]   snow_corr_q;
  logic signed [ddsim_pkg::TempW-1:0] rain_thr_q;
  logic signed [ddsim_pkg::TempW-1:0] melt_thr_q;
  logic [ddsim_pkg::FactorW-1:0] snow_fact_q;
  logic [ddsim_pkg::FactorW-1:0] ice_fact_q;
  logic [StoreW-1:0]             init_store_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snow_corr_q  <= ddsim_pkg::SnowCorrRst;
      rain_thr_q   <= '0;
      melt_thr_q   <= '0;
      snow_fact_q  <= ddsim_pkg::SnowFactRst;
      ice_fact_q   <= ddsim_pkg::IceFactRst;
      init_store_q <= '0;
    end else if (cfg_we_i) begin
      // Indexes past the list fall into the default arm and are dropped.
      unique case (cfg_idx_i)
        ddsim_pkg::REG_SNOW_CORR:  snow_corr_q  <= cfg_data_i[ddsim_pkg::CorrW-1:0];
        ddsim_pkg::REG_RAIN_THR:   rain_thr_q   <= cfg_data_i[ddsim_pkg::TempW-1:0];
        ddsim_pkg::REG_MELT_THR:   melt_thr_q   <= cfg_data_i[ddsim_pkg::TempW-1:0];
        ddsim_pkg::REG_SNOW_FACT:  snow_fact_q  <= cfg_data_i[ddsim_pkg::FactorW-1:0];
        ddsim_pkg::REG_ICE_FACT:   ice_fact_q   <= cfg_data_i[ddsim_pkg::FactorW-1:0];
        ddsim_pkg::REG_INIT_STORE: init_store_q <= cfg_data_i[StoreW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input field unpacking
  // ---------------------------------------------------------------------------
  logic                               in_first;
  logic signed [ddsim_pkg::TempW-1:0] in_temp;
  logic [ddsim_pkg::PrecipW-1:0]      in_precip;
  logic [ddsim_pkg::AreaW-1:0]        in_area;

  assign in_first  = s_axis_tdata[0];
  assign in_temp   = s_axis_tdata[14:1];
  assign in_precip = s_axis_tdata[30:15];
  assign in_area   = s_axis_tdata[47:31];

  // ---------------------------------------------------------------------------
  // Sequencer and working registers
  // ---------------------------------------------------------------------------
  ddsim_pkg::state_e state_q, state_d;

  logic                          rain_q;      // step is a rain step
  logic                          warm_q;      // step is above melt threshold
  logic [ddsim_pkg::TempW-1:0]   diff_q;      // air_temp - melt_threshold
  logic [ddsim_pkg::PrecipW-1:0] precip_q;
  logic [ddsim_pkg::AreaW-1:0]   area_q;
  logic [StoreW-1:0]             store_q;
  logic [ProdW-1:0]              prod_q;
  logic [SnowW-1:0]              snow_q;
  logic [StoreW-1:0]             smelt_q, imelt_q, mtot_q;
  logic [RunW-1:0]               acc_q, runoff_q;

  logic in_xfer, out_load;
  logic signed [ddsim_pkg::TempW:0] diff_full;

  assign s_axis_tready = (state_q == ddsim_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ddsim_pkg::ST_OUT) && (!m_axis_tvalid || m_axis_tready);
  assign diff_full     = (ddsim_pkg::TempW+1)'(in_temp) - (ddsim_pkg::TempW+1)'(melt_thr_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ddsim_pkg::ST_IDLE: if (in_xfer) state_d = ddsim_pkg::ST_SNOW;
      ddsim_pkg::ST_SNOW: state_d = ddsim_pkg::ST_MELT;
      ddsim_pkg::ST_MELT: state_d = ddsim_pkg::ST_UPD;
      ddsim_pkg::ST_UPD:  state_d = ddsim_pkg::ST_RUN;
      ddsim_pkg::ST_RUN:  state_d = ddsim_pkg::ST_OUT;
      ddsim_pkg::ST_OUT:  if (out_load) state_d = ddsim_pkg::ST_IDLE;
      default:            state_d = ddsim_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: snowfall, then melt, then area scaling
  // ---------------------------------------------------------------------------
  logic [ddsim_pkg::MulAW-1:0] mul_a;
  logic [ddsim_pkg::MulBW-1:0] mul_b;
  logic [ProdW-1:0]            prod_d;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ddsim_pkg::ST_SNOW: begin
        mul_a = ddsim_pkg::MulAW'(precip_q);
        mul_b = ddsim_pkg::MulBW'(snow_corr_q);
      end
      ddsim_pkg::ST_MELT: begin
        // Bare ice melts only when the store is exactly empty.
        mul_a = ddsim_pkg::MulAW'(diff_q);
        mul_b = (store_q == '0) ? ddsim_pkg::MulBW'(ice_fact_q)
                                : ddsim_pkg::MulBW'(snow_fact_q);
      end
      ddsim_pkg::ST_RUN: begin
        mul_a = runoff_q;
        mul_b = area_q;
      end
      default: ;
    endcase
    prod_d = ProdW'(mul_a) * ProdW'(mul_b);
  end

  // ---------------------------------------------------------------------------
  // Rounding, limiting and store update
  // ---------------------------------------------------------------------------
  logic [ProdW-1:0]  snow_rnd, melt_rnd;
  logic [SnowW-1:0]  snow_d;
  logic [StoreW-1:0] melt_raw, smelt_d, imelt_d, mtot_d;
  logic [RunW-1:0]   sum_d;

  assign snow_rnd = prod_q + ddsim_pkg::SnowRnd;
  assign melt_rnd = prod_q + ddsim_pkg::MeltRnd;
  assign snow_d   = rain_q ? '0 : snow_rnd[14 +: SnowW];
  // Melt product is at most 27 bits, so its rounded value fits the store width.
  assign melt_raw = melt_rnd[8 +: StoreW];

  always_comb begin
    smelt_d = '0;
    imelt_d = '0;
    if (warm_q) begin
      if (store_q == '0) begin
        imelt_d = melt_raw;
      end else begin
        smelt_d = (melt_raw > store_q) ? store_q : melt_raw;
      end
    end
    mtot_d = smelt_d + imelt_d;
    sum_d  = RunW'(store_q) - RunW'(smelt_d) + RunW'(snow_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddsim_pkg::ST_IDLE;
      store_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer && in_first) begin
        store_q <= init_store_q;
      end else if (state_q == ddsim_pkg::ST_UPD) begin
        // Saturate the store at its maximum after snowfall is added.
        store_q <= sum_d[StoreW] ? ddsim_pkg::StoreMax : sum_d[StoreW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rain_q   <= in_temp > rain_thr_q;
      warm_q   <= in_temp > melt_thr_q;
      diff_q   <= diff_full[ddsim_pkg::TempW-1:0];
      precip_q <= in_precip;
      area_q   <= in_area;
    end
    if (state_q == ddsim_pkg::ST_SNOW || state_q == ddsim_pkg::ST_MELT ||
        state_q == ddsim_pkg::ST_RUN) begin
      prod_q <= prod_d;
    end
    if (state_q == ddsim_pkg::ST_MELT) begin
      snow_q <= snow_d;
    end
    if (state_q == ddsim_pkg::ST_UPD) begin
      smelt_q  <= smelt_d;
      imelt_q  <= imelt_d;
      mtot_q   <= mtot_d;
      acc_q    <= RunW'(snow_q) - RunW'(mtot_d);
      runoff_q <= RunW'(mtot_d) + (rain_q ? RunW'(precip_q) : '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a result until its transfer
  // ---------------------------------------------------------------------------
  logic [ProdW-1:0] run_rnd;
  logic [RunW-1:0]  scaled;

  assign run_rnd = prod_q + ddsim_pkg::RunRnd;
  // Area scales above one can push the product past the field: saturate.
  assign scaled  = (run_rnd[ProdW-1:16+RunW] != '0) ? ddsim_pkg::RunMax
                                                   : run_rnd[16 +: RunW];

  logic m_valid_q;
  logic [ddsim_pkg::OutDataW-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {3'b000, scaled, runoff_q, acc_q, mtot_q, imelt_q, smelt_q,
                   store_q, snow_q, (rain_q ? precip_q : '0)};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[tb/tb_degree_day_snow_ice_melt.sv]
// ----------------------------------------------------------------------------
// tb_degree_day_snow_ice_melt: self-checking bench of the snow and ice melt
// Drives time steps on the input stream and register writes between runs,
// predicts every result with an in-bench model of the store and the melt
// arithmetic, and compares each output transfer field by field. A short
// directed run covers thresholds, extremes, bare ice and store saturation;
// random runs under several register settings follow, with random gaps on
// both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_degree_day_snow_ice_melt;

  localparam int Phases        = 6;
  localparam int PhaseSteps    = 90;
  localparam int IdleCycles    = 10;
  localparam int EndCycles     = 24;
  localparam int HoldOffCycles = 150;
  localparam int QuietLimit    = 3000;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [ddsim_pkg::CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [ddsim_pkg::CfgIdxW-1:0] RegSpareHi = 3'd7;

  // One time step, packed as on s_axis_tdata (first_step in bit 0).
  typedef struct packed {
    logic [ddsim_pkg::AreaW-1:0]        area;
    logic [ddsim_pkg::PrecipW-1:0]      precip;
    logic signed [ddsim_pkg::TempW-1:0] temp;
    logic                               first;
  } step_t;

  // One result, packed as on m_axis_tdata (rain_out in the low bits).
  typedef struct packed {
    logic [2:0]                    fill;
    logic [ddsim_pkg::RunW-1:0]    scaled;
    logic [ddsim_pkg::RunW-1:0]    runoff;
    logic [ddsim_pkg::RunW-1:0]    acc;
    logic [ddsim_pkg::StoreW-1:0]  mtot;
    logic [ddsim_pkg::StoreW-1:0]  imelt;
    logic [ddsim_pkg::StoreW-1:0]  smelt;
    logic [ddsim_pkg::StoreW-1:0]  store;
    logic [ddsim_pkg::SnowW-1:0]   snow;
    logic [ddsim_pkg::PrecipW-1:0] rain;
  } melt_res_t;

  // Directed stimulus row: either a register write or a step, and for a few
  // steps a result typed in by hand.
  typedef struct {
    bit                             is_cfg;
    logic [ddsim_pkg::CfgIdxW-1:0]  idx;
    logic [ddsim_pkg::CfgDataW-1:0] val;
    step_t                          step;
    bit                             typed;
    melt_res_t                      want;
  } plan_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic [ddsim_pkg::InDataW-1:0]  s_axis_tdata;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [ddsim_pkg::OutDataW-1:0] m_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic                           cfg_we_i;
  logic [ddsim_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [ddsim_pkg::CfgDataW-1:0] cfg_data_i;

  // Bench copy of the registers and of the snow water equivalent store.
  longint corr_cfg     = ddsim_pkg::SnowCorrRst;
  longint rain_thr_cfg = 0;
  longint melt_thr_cfg = 0;
  longint snow_fac_cfg = ddsim_pkg::SnowFactRst;
  longint ice_fac_cfg  = ddsim_pkg::IceFactRst;
  longint swe_init_cfg = 0;
  longint swe          = 0;

  melt_res_t predicted[$];   // results owed by the block, oldest first
  melt_res_t got;

  int  err_count    = 0;
  int  steps_sent   = 0;
  int  results_seen = 0;
  int  n_writes     = 0;
  int  n_rain       = 0;
  int  n_ice        = 0;
  int  n_emptied    = 0;
  int  n_full       = 0;
  int  quiet_cycles = 0;
  bit  steady_feed  = 1'b0;
  bit  held_off     = 1'b0;

  degree_day_snow_ice_melt dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Advance the bench store by one step and return the result it owes.
  // All products are exact, then rounded to nearest with ties up.
  function automatic melt_res_t hydro_step(input step_t s);
    melt_res_t r;
    longint t, rain, snow, sm, im, mt, gross, acc, run, scl;
    r    = '0;
    rain = 0;
    snow = 0;
    sm   = 0;
    im   = 0;
    t    = $signed(s.temp);
    // Split precipitation: strictly above the rain threshold it is rain.
    if (t > rain_thr_cfg) begin
      rain = s.precip;
      n_rain++;
    end else begin
      snow = (longint'(s.precip) * corr_cfg + 8192) >> 14;
    end
    if (s.first) swe = swe_init_cfg;
    // Melt only strictly above the melt threshold. An empty store means
    // bare ice, which melts by its own factor; snow melt is capped at the store.
    if (t > melt_thr_cfg) begin
      if (swe == 0) begin
        im = ((t - melt_thr_cfg) * ice_fac_cfg + 128) >> 8;
        n_ice++;
      end else begin
        sm = ((t - melt_thr_cfg) * snow_fac_cfg + 128) >> 8;
        if (sm > swe) begin
          sm = swe;
          n_emptied++;
        end
      end
    end
    mt    = sm + im;
    gross = swe - sm + snow;
    if (gross > ddsim_pkg::StoreMax) begin
      swe = ddsim_pkg::StoreMax;
      n_full++;
    end else begin
      swe = gross;
    end
    // Accumulation keeps the unsaturated difference.
    acc = snow - mt;
    run = mt + rain;
    scl = (run * longint'(s.area) + 32768) >> 16;
    if (scl > ddsim_pkg::RunMax) scl = ddsim_pkg::RunMax;
    r.rain   = rain[ddsim_pkg::PrecipW-1:0];
    r.snow   = snow[ddsim_pkg::SnowW-1:0];
    r.store  = swe[ddsim_pkg::StoreW-1:0];
    r.smelt  = sm[ddsim_pkg::StoreW-1:0];
    r.imelt  = im[ddsim_pkg::StoreW-1:0];
    r.mtot   = mt[ddsim_pkg::StoreW-1:0];
    r.acc    = acc[ddsim_pkg::RunW-1:0];
    r.runoff = run[ddsim_pkg::RunW-1:0];
    r.scaled = scl[ddsim_pkg::RunW-1:0];
    return r;
  endfunction

  function automatic step_t make_step(input bit first, input int temp,
                                      input int precip, input int area);
    step_t s;
    s.first  = first;
    s.temp   = temp[ddsim_pkg::TempW-1:0];
    s.precip = precip[ddsim_pkg::PrecipW-1:0];
    s.area   = area[ddsim_pkg::AreaW-1:0];
    return s;
  endfunction

  function automatic plan_row_t item_row(input bit first, input int temp,
                                         input int precip, input int area);
    plan_row_t row;
    row        = '{default: '0};
    row.step   = make_step(first, temp, precip, area);
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [ddsim_pkg::CfgIdxW-1:0] idx,
                                        input logic [ddsim_pkg::CfgDataW-1:0] val);
    plan_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    return row;
  endfunction

  function automatic melt_res_t res_of(input longint rain, snow, store, smelt,
                                       imelt, mtot, acc, runoff, scaled);
    melt_res_t r;
    r        = '0;
    r.rain   = rain[ddsim_pkg::PrecipW-1:0];
    r.snow   = snow[ddsim_pkg::SnowW-1:0];
    r.store  = store[ddsim_pkg::StoreW-1:0];
    r.smelt  = smelt[ddsim_pkg::StoreW-1:0];
    r.imelt  = imelt[ddsim_pkg::StoreW-1:0];
    r.mtot   = mtot[ddsim_pkg::StoreW-1:0];
    r.acc    = acc[ddsim_pkg::RunW-1:0];
    r.runoff = runoff[ddsim_pkg::RunW-1:0];
    r.scaled = scaled[ddsim_pkg::RunW-1:0];
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  // Temperature close to a threshold, kept inside the field's range.
  function automatic int near_temp(input longint c);
    int t;
    t = int'(c) + int'($urandom_range(0, 100)) - 50;
    if (t > 6000) t = 6000;
    if (t < -6000) t = -6000;
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report(input string field, input longint gotv, input longint wantv);
    $display("mismatch on %s at result %0d: got %0d, want %0d",
             field, results_seen, gotv, wantv);
    err_count++;
  endtask

  task automatic check_result(input melt_res_t g, input melt_res_t w);
    if (g.rain   !== w.rain)   report("rain_out", g.rain, w.rain);
    if (g.snow   !== w.snow)   report("snow_out", g.snow, w.snow);
    if (g.store  !== w.store)  report("snow_store_out", g.store, w.store);
    if (g.smelt  !== w.smelt)  report("snow_melt_out", g.smelt, w.smelt);
    if (g.imelt  !== w.imelt)  report("ice_melt_out", g.imelt, w.imelt);
    if (g.mtot   !== w.mtot)   report("total_melt_out", g.mtot, w.mtot);
    if (g.acc    !== w.acc)    report("accumulation_out", $signed(g.acc), $signed(w.acc));
    if (g.runoff !== w.runoff) report("runoff_out", g.runoff, w.runoff);
    if (g.scaled !== w.scaled) report("scaled_runoff_out", g.scaled, w.scaled);
    if (g.fill   !== w.fill)   report("tdata fill bits", g.fill, w.fill);
  endtask

  // Sample output transfers before any update of this edge lands.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = melt_res_t'(m_axis_tdata);
      if (predicted.size() == 0) report("result with no step pending", 0, 0);
      else check_result(got, predicted.pop_front());
      results_seen++;
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no transfer for %0d cycles, %0d results still owed",
               quiet_cycles, predicted.size());
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driving. Every task is entered just after a rising edge.
  // --------------------------------------------------------------------------

  // Write one register, then drop the enable for a cycle before returning.
  task automatic write_reg(input logic [ddsim_pkg::CfgIdxW-1:0] idx,
                           input logic [ddsim_pkg::CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    // Mask to the register width; thresholds sign-extend from bit 13.
    case (idx)
      ddsim_pkg::REG_SNOW_CORR:  corr_cfg     = val[ddsim_pkg::CorrW-1:0];
      ddsim_pkg::REG_RAIN_THR:   rain_thr_cfg = $signed(val[ddsim_pkg::TempW-1:0]);
      ddsim_pkg::REG_MELT_THR:   melt_thr_cfg = $signed(val[ddsim_pkg::TempW-1:0]);
      ddsim_pkg::REG_SNOW_FACT:  snow_fac_cfg = val[ddsim_pkg::FactorW-1:0];
      ddsim_pkg::REG_ICE_FACT:   ice_fac_cfg  = val[ddsim_pkg::FactorW-1:0];
      ddsim_pkg::REG_INIT_STORE: swe_init_cfg = val[ddsim_pkg::StoreW-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // Offer one step after a random gap and hold it until the transfer; then
  // queue the result it owes (the hand-typed one where the row has it).
  task automatic send_step(input step_t s, input bit typed, input melt_res_t want);
    int gap;
    melt_res_t calc;
    gap = steady_feed ? 0 : gap_len();
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= ddsim_pkg::InDataW'({$urandom, $urandom});
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    calc = hydro_step(s);
    predicted.push_back(typed ? want : calc);
    steps_sent++;
  endtask

  // Drop valid, wait until every owed result has arrived, then idle.
  task automatic settle(input int extra);
    s_axis_tvalid <= 1'b0;
    while (predicted.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Receiver: random stalls and ready bursts, plus one long hold-off once
  // traffic is flowing, so the block fills and stops taking steps.
  initial begin : sink
    int stall, burst;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && results_seen >= 120) begin
        stall    = HoldOffCycles;
        held_off = 1'b1;
      end else begin
        stall = gap_len();
      end
      if ($urandom_range(0, 9) == 0) burst = $urandom_range(30, 60);
      else burst = $urandom_range(1, 8);
      repeat (stall) begin
        @(posedge clk_i);
        m_axis_tready <= 1'b0;
      end
      repeat (burst) begin
        @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t plan[$];
    plan_row_t row;
    int p, k, t, pr, ar;
    int corr_v, rthr_v, mthr_v, sfac_v, ifac_v, init_v;
    bit first;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed run, starting from the reset register values.
    // After reset with nothing loaded: a cold dry step gives all zeros.
    row = item_row(1, 0, 0, 65536);
    row.typed = 1'b1;
    row.want  = res_of(0, 0, 0, 0, 0, 0, 0, 0, 0);
    plan.push_back(row);
    // Coldest step, full precipitation at unit correction: all of it is snow.
    row = item_row(0, -6000, 65535, 65536);
    row.typed = 1'b1;
    row.want  = res_of(0, 65535, 65535, 0, 0, 0, 65535, 0, 0);
    plan.push_back(row);
    plan.push_back(item_row(0, 6000, 65535, 65536));   // warmest: rain and snow melt
    plan.push_back(item_row(0, 1, 1000, 0));           // just above both, zero area
    // Reload an empty store on a warm dry step: bare ice melts at 6.0.
    row = item_row(1, 6000, 0, 65536);
    row.typed = 1'b1;
    row.want  = res_of(0, 0, 0, 0, 36000, 36000, -36000, 36000, 36000);
    plan.push_back(row);
    plan.push_back(item_row(0, 0, 65535, 131071));     // at threshold, area above one
    // Full store plus snowfall: the store saturates, accumulation does not.
    plan.push_back(cfg_row(ddsim_pkg::REG_INIT_STORE, ddsim_pkg::StoreMax));
    row = item_row(1, -6000, 65535, 65536);
    row.typed = 1'b1;
    row.want  = res_of(0, 65535, ddsim_pkg::StoreMax, 0, 0, 0, 65535, 0, 0);
    plan.push_back(row);
    plan.push_back(item_row(0, 6000, 0, 131071));
    // Steep snow factor on a small store: melt is capped, then ice is bare.
    plan.push_back(cfg_row(ddsim_pkg::REG_SNOW_FACT, 24'hFFFFFF));
    plan.push_back(cfg_row(ddsim_pkg::REG_INIT_STORE, 24'd100));
    plan.push_back(item_row(1, 6000, 0, 65536));
    plan.push_back(item_row(0, 6000, 0, 65536));
    // Extreme thresholds and factors; the spare indexes must be ignored.
    plan.push_back(cfg_row(ddsim_pkg::REG_RAIN_THR, 24'(-5000)));
    plan.push_back(cfg_row(ddsim_pkg::REG_MELT_THR, 24'(5000)));
    plan.push_back(cfg_row(ddsim_pkg::REG_SNOW_CORR, 24'hFFFFFF));
    plan.push_back(cfg_row(ddsim_pkg::REG_ICE_FACT, 24'hFFFFFF));
    plan.push_back(cfg_row(RegSpareLo, 24'h000000));
    plan.push_back(cfg_row(RegSpareHi, 24'hFFFFFF));
    plan.push_back(item_row(0, -5000, 65535, 65536));  // at rain threshold: snow
    plan.push_back(item_row(0, -4999, 65535, 65536));  // one above: rain
    plan.push_back(item_row(0, 5000, 0, 65536));       // at melt threshold: no melt
    plan.push_back(item_row(0, 5001, 0, 65536));       // one above: melt
    plan.push_back(cfg_row(ddsim_pkg::REG_SNOW_CORR, 24'd0));
    plan.push_back(cfg_row(ddsim_pkg::REG_SNOW_FACT, 24'd0));
    plan.push_back(item_row(0, -6000, 65535, 1));      // zero correction, tiny area
    plan.push_back(item_row(0, 6000, 65535, 65536));   // zero factor, store not empty

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle(IdleCycles);
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_step(plan[i].step, plan[i].typed, plan[i].want);
      end
    end

    // Random runs: one register setting per run, each run opens a new series.
    for (p = 0; p < Phases; p++) begin
      settle(IdleCycles);
      case (p)
        0: begin
          corr_v = 65535; rthr_v = 5000; mthr_v = -5000;
          sfac_v = 8191;  ifac_v = 8191; init_v = ddsim_pkg::StoreMax;
        end
        1: begin
          corr_v = 0;  rthr_v = -5000; mthr_v = 5000;
          sfac_v = 0;  ifac_v = 0;     init_v = 0;
        end
        default: begin
          if ($urandom_range(0, 1) == 0) corr_v = $urandom_range(8000, 30000);
          else corr_v = $urandom_range(0, 65535);
          rthr_v = int'($urandom_range(0, 10000)) - 5000;
          mthr_v = int'($urandom_range(0, 10000)) - 5000;
          sfac_v = $urandom_range(0, 8191);
          ifac_v = $urandom_range(0, 8191);
          case ($urandom_range(0, 2))
            0:       init_v = $urandom_range(0, 3000);
            1:       init_v = $urandom_range(0, 300000);
            default: init_v = $urandom_range(0, ddsim_pkg::StoreMax);
          endcase
        end
      endcase
      // Upper data bits carry noise; the block must mask them off.
      write_reg(ddsim_pkg::REG_SNOW_CORR,  {8'($urandom), 16'(corr_v)});
      write_reg(ddsim_pkg::REG_RAIN_THR,   {10'($urandom), 14'(rthr_v)});
      write_reg(ddsim_pkg::REG_MELT_THR,   {10'($urandom), 14'(mthr_v)});
      write_reg(ddsim_pkg::REG_SNOW_FACT,  {11'($urandom), 13'(sfac_v)});
      write_reg(ddsim_pkg::REG_ICE_FACT,   {11'($urandom), 13'(ifac_v)});
      write_reg(ddsim_pkg::REG_INIT_STORE, 24'(init_v));
      write_reg((p % 2) ? RegSpareHi : RegSpareLo, 24'($urandom));
      steady_feed = (p == 2);

      for (k = 0; k < PhaseSteps; k++) begin
        first = (k == 0) || ($urandom_range(0, 19) == 0);
        case ($urandom_range(0, 3))
          0:       t = near_temp(melt_thr_cfg);
          1:       t = near_temp(rain_thr_cfg);
          default: t = int'($urandom_range(0, 12000)) - 6000;
        endcase
        case ($urandom_range(0, 9))
          0:       pr = 0;
          1:       pr = 65535;
          default: pr = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 9))
          0:       ar = 0;
          1:       ar = 65536;
          2:       ar = $urandom_range(65537, 131071);
          default: ar = $urandom_range(0, 65536);
        endcase
        send_step(make_step(first, t, pr, ar), 1'b0, '0);
      end
    end
    steady_feed = 1'b0;

    // Drain, then idle so a stray extra result would still be caught.
    settle(EndCycles);
    $display("summary: %0d steps sent, %0d results compared, %0d register writes",
             steps_sent, results_seen, n_writes);
    $display("summary: %0d rain, %0d bare ice, %0d melted out, %0d saturated, stall %0s",
             n_rain, n_ice, n_emptied, n_full, held_off ? "done" : "missed");
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ddsim_pkg.sv
design/degree_day_snow_ice_melt.sv
tb/tb_degree_day_snow_ice_melt.sv
